[hdl/region_address_translator_macros.svh]
// Assertion macros for the region address translator checker.
`ifndef REGION_ADDRESS_TRANSLATOR_MACROS_SVH
`define REGION_ADDRESS_TRANSLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("region address translator: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("region address translator: next-cycle check failed");

`endif

[hdl/rat_pkg.sv]
// ----------------------------------------------------------------------------
// rat_pkg
// Shared types and codes of the region address translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rat_pkg;

  localparam int unsigned LEN_BITS = 32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_XLATE = 2'd1,
    OP_RANGE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_OVERLAP  = 3'd1,
    STAT_UNMAPPED = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_SPAN     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_RES
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the request payload
    logic cmp;   // register per-entry compare vectors
    logic sel;   // pick entry, update table on add
    logic res;   // load the result register
  } rat_cmd_t;

endpackage

[hdl/rat_if.sv]
// ----------------------------------------------------------------------------
// rat_in_if / rat_out_if
// Valid/ready channels for requests and results of the translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] vm_addr;
  logic [31:0] vm_size;
  logic [31:0] file_offset;
  logic [31:0] file_size;

  modport source (output valid, op, vm_addr, vm_size, file_offset, file_size,
                  input ready);
  modport sink (input valid, op, vm_addr, vm_size, file_offset, file_size,
                output ready);
endinterface

interface rat_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] file_addr;
  logic [31:0] file_len;

  modport source (output valid, status, file_addr, file_len, input ready);
  modport sink (input valid, status, file_addr, file_len, output ready);
endinterface

[hdl/rat_ctrl.sv]
// ----------------------------------------------------------------------------
// rat_ctrl
// Sequencer: accept, compare, select, result; owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output rat_pkg::rat_cmd_t cmd_o
);
  import rat_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = S_RES;
      end
      S_RES: begin
        // hold until the result register is free or drains this cycle
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.res   = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

[hdl/rat_dp.sv]
// ----------------------------------------------------------------------------
// rat_dp
// Region table, per-entry comparators, entry select and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rat_dp #(
  parameter int unsigned REGIONS   = 16,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rat_pkg::rat_cmd_t cmd_i,
  input  logic [1:0]        op_i,
  input  logic [31:0]       vm_addr_i,
  input  logic [31:0]       vm_size_i,
  input  logic [31:0]       file_offset_i,
  input  logic [31:0]       file_size_i,
  output logic [2:0]        status_o,
  output logic [31:0]       file_addr_o,
  output logic [31:0]       file_len_o
);
  import rat_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned LW = LEN_BITS;
  localparam int unsigned CW = (AW > LW) ? AW : LW;
  localparam int unsigned IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  // [a, a+la) meets [b, b+lb); zero length never meets
  function automatic logic meet(input logic [AW-1:0] a, input logic [LW-1:0] la,
                                input logic [AW-1:0] b, input logic [LW-1:0] lb);
    logic [AW-1:0] d;
    logic          r;
    r = 1'b0;
    d = '0;
    if (la != '0 && lb != '0) begin
      if (a >= b) begin
        d = a - b;
        r = CW'(d) < CW'(lb);
      end else begin
        d = b - a;
        r = CW'(d) < CW'(la);
      end
    end
    return r;
  endfunction

  // request capture
  op_e           op_q;
  logic [AW-1:0] va_q, fa_q;
  logic [LW-1:0] vl_q, fl_q;

  // region table
  logic [AW-1:0]      vbase_q [REGIONS];
  logic [LW-1:0]      vlen_q  [REGIONS];
  logic [AW-1:0]      fbase_q [REGIONS];
  logic [LW-1:0]      flen_q  [REGIONS];
  logic [REGIONS-1:0] valid_q;

  // compare stage
  logic [REGIONS-1:0] hit_d, hit_q, meet_d, meet_q;

  // select stage
  logic [IW-1:0] hit_idx, free_idx;
  logic          found, has_free, add_wr;
  status_e       add_st_d, add_st_q;
  logic          sel_found_q;
  logic [LW-1:0] sel_off_q, sel_vlen_q, sel_flen_q;
  logic [AW-1:0] sel_fbase_q;

  // result stage
  status_e       st_d, st_q;
  logic [31:0]   faddr_d, faddr_q, flen_d, flen_q2;
  logic [LW-1:0] vrem, frest;
  logic [AW-1:0] fsum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(op_i);
      va_q <= AW'(vm_addr_i);
      vl_q <= vm_size_i;
      fa_q <= AW'(file_offset_i);
      fl_q <= file_size_i;
    end
  end

  always_comb begin
    for (int i = 0; i < REGIONS; i++) begin
      hit_d[i]  = valid_q[i] && (vlen_q[i] != '0) && (va_q >= vbase_q[i]) &&
                  (CW'(va_q - vbase_q[i]) < CW'(vlen_q[i]));
      meet_d[i] = valid_q[i] && (meet(va_q, vl_q, vbase_q[i], vlen_q[i]) ||
                                 meet(fa_q, fl_q, fbase_q[i], flen_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      hit_q  <= hit_d;
      meet_q <= meet_d;
    end
  end

  // lowest-index priority encoders
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    found    = 1'b0;
    has_free = 1'b0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = IW'(i);
        found   = 1'b1;
      end
      if (!valid_q[i]) begin
        free_idx = IW'(i);
        has_free = 1'b1;
      end
    end
  end

  always_comb begin
    add_wr = 1'b0;
    priority if (vl_q == '0 && fl_q == '0) begin
      add_st_d = STAT_OK;
    end else if (|meet_q) begin
      add_st_d = STAT_OVERLAP;
    end else if (!has_free) begin
      add_st_d = STAT_FULL;
    end else begin
      add_st_d = STAT_OK;
      add_wr   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      add_st_q    <= add_st_d;
      sel_found_q <= found;
      // offset is below the region length, so it fits a length word
      sel_off_q   <= LW'(va_q - vbase_q[hit_idx]);
      sel_vlen_q  <= vlen_q[hit_idx];
      sel_fbase_q <= fbase_q[hit_idx];
      sel_flen_q  <= flen_q[hit_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.sel && op_q == OP_ADD && add_wr) begin
      valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel && op_q == OP_ADD && add_wr) begin
      vbase_q[free_idx] <= va_q;
      vlen_q[free_idx]  <= vl_q;
      fbase_q[free_idx] <= fa_q;
      flen_q[free_idx]  <= fl_q;
    end
  end

  always_comb begin
    vrem    = sel_vlen_q - sel_off_q;
    frest   = sel_flen_q - sel_off_q;
    fsum    = sel_fbase_q + AW'(sel_off_q);
    st_d    = STAT_UNMAPPED;
    faddr_d = '0;
    flen_d  = '0;
    unique case (op_q)
      OP_ADD: st_d = add_st_q;
      OP_XLATE, OP_RANGE: begin
        if (sel_found_q) begin
          if (op_q == OP_RANGE && vl_q > vrem) begin
            st_d = STAT_SPAN;
          end else if (sel_off_q < sel_flen_q) begin
            st_d    = STAT_OK;
            faddr_d = 32'(fsum);
            if (op_q == OP_RANGE) begin
              flen_d = (vl_q < frest) ? vl_q : frest;
            end
          end
        end
      end
      default: st_d = STAT_UNMAPPED;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res) begin
      st_q    <= st_d;
      faddr_q <= faddr_d;
      flen_q2 <= flen_d;
    end
  end

  assign status_o    = st_q;
  assign file_addr_o = faddr_q;
  assign file_len_o  = flen_q2;

endmodule

[hdl/region_address_translator.sv]
// ----------------------------------------------------------------------------
// region_address_translator
// Region table with add, address translate and range translate requests.
//   req_i (sink): op, vm_addr, vm_size, file_offset, file_size. An add
//     stores a region in the lowest free slot unless both its sizes are zero,
//     its virtual or file range overlaps a stored one or the table is full.
//   rsp_o (source): status, file_addr, file_len; one result per request.
//   Steps: after the request transfer the sequencer compares all entries,
//     selects the entry and updates the table, then forms the result in the
//     result register. It takes the next request only after that, in its
//     idle step of the four-step sequence; one request is in flight at a time.
//   The result register lets the next request start while a result waits;
//   if the receiver stalls, the sequencer holds in its last step until the
//   result register frees up, and req_i.ready stays low meanwhile.
//   Reset: all valid bits clear at once, so the table is empty right away;
//   no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module region_address_translator #(
  parameter int unsigned REGIONS   = 16,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rat_in_if.sink   req_i,
  rat_out_if.source rsp_o
);
  import rat_pkg::*;

  rat_cmd_t cmd;
  logic     req_ready;
  logic     rsp_valid;

  // sequencer: one step per cycle unless a stalled result holds its last step, owns both handshakes
  rat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_ready),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_o.ready),
    .cmd_o      (cmd)
  );

  // table, comparators and result payload register
  rat_dp #(
    .REGIONS  (REGIONS),
    .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (req_i.op),
    .vm_addr_i    (req_i.vm_addr),
    .vm_size_i    (req_i.vm_size),
    .file_offset_i(req_i.file_offset),
    .file_size_i  (req_i.file_size),
    .status_o     (rsp_o.status),
    .file_addr_o  (rsp_o.file_addr),
    .file_len_o   (rsp_o.file_len)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;

endmodule

[hdl/rat_checker.sv]
// ----------------------------------------------------------------------------
// rat_checker
// Port-level checks of the region address translator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "region_address_translator_macros.svh"

module rat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_file_addr_i,
  input logic [31:0] rsp_file_len_i
);
  import rat_pkg::*;

  logic rsp_stall;
  logic rsp_bad;

  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_bad   = rsp_valid_i && (rsp_status_i != STAT_OK);

  `RAT_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i)
  `RAT_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_stall, $stable({rsp_status_i, rsp_file_addr_i, rsp_file_len_i}))
  `RAT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  `RAT_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, rsp_bad, rsp_file_addr_i == '0 && rsp_file_len_i == '0)

endmodule

bind region_address_translator rat_checker u_rat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_file_addr_i(rsp_o.file_addr),
  .rsp_file_len_i (rsp_o.file_len)
);
